>>> rtl/gsfp_pkg.sv
`timescale 1ns / 1ps

package gsfp_pkg;

    // Marker characters
    localparam logic [7:0] CHAR_LT = 8'h3C;  // '<'
    localparam logic [7:0] CHAR_I  = 8'h49;  // 'I'
    localparam logic [7:0] CHAR_D  = 8'h44;  // 'D'

    // Info bytes skipped after the start marker
    localparam int INFO_BYTES = 5;

    // Bytes removed from the front of a frame with a bad header
    localparam int DROP_BYTES = 7;

    // Ring store: a power of two, at least the largest frame
    localparam int STORE_SLOTS = 64;
    localparam int ADDR_W      = $clog2(STORE_SLOTS);

    // Idle tick counter and timeout register
    localparam int              TICK_W        = 24;
    localparam logic [TICK_W-1:0] TICK_MAX    = {TICK_W{1'b1}};
    localparam logic [TICK_W-1:0] TIMEOUT_RST = 24'd2000;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAN    = 2'd0,
        KIND_RESYNC  = 2'd1,
        KIND_TIMEOUT = 2'd2
    } t_kind;

    // Store read address selection
    typedef enum logic [2:0] {
        RD_HDR0,
        RD_HDR1,
        RD_HI,
        RD_LO,
        RD_HI_NEXT
    } t_rd_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic    enter_read;
        logic    wr_byte;
        logic    tick;
        logic    ch_clr;
        logic    ch_inc;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    hdr0_latch;
        logic    hi_latch;
        logic    drop;
        logic    frame_done;
        logic    load_out;
        t_kind   out_kind;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic frame_full;
        logic tout_hit;
        logic hdr_ok;
        logic ch_last;
        logic slot_free;
    } t_sts;

endpackage

>>> rtl/gsfp_in_if.sv
`timescale 1ns / 1ps

interface gsfp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

>>> rtl/gsfp_out_if.sv
`timescale 1ns / 1ps

interface gsfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        last;

    modport source (output valid, output kind, output channel_index,
                    output channel_value, output last, input ready);
    modport sink   (input valid, input kind, input channel_index,
                    input channel_value, input last, output ready);
endinterface

>>> rtl/gsfp_datapath.sv
`timescale 1ns / 1ps

module gsfp_datapath
    import gsfp_pkg::*;
#(
    parameter int FRAME_BYTES   = 36,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    input  logic [7:0]        i_rx_byte,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    gsfp_out_if.source        o_out
);

    localparam int HELD_W = $clog2(FRAME_BYTES);
    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [7:0]        r_mem [STORE_SLOTS];
    logic [7:0]        r_rdata;
    logic [ADDR_W-1:0] r_base;
    logic [HELD_W-1:0] r_held;
    logic [TICK_W-1:0] r_idle;
    logic [TICK_W-1:0] r_timeout;
    logic [CH_W-1:0]   r_ch;
    logic              r_hdr0_ok;
    logic [7:0]        r_hi;
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [3:0]        r_out_index;
    logic [15:0]       r_out_value;
    logic              r_out_last;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_offset;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] ch_x2;

    // Ring addressing: logical byte i sits at base + i
    assign wr_addr = r_base + ADDR_W'(r_held);
    assign ch_x2   = ADDR_W'(r_ch) << 1;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_HDR0:    rd_offset = '0;
            RD_HDR1:    rd_offset = ADDR_W'(1);
            RD_HI:      rd_offset = ch_x2 + ADDR_W'(2);
            RD_LO:      rd_offset = ch_x2 + ADDR_W'(3);
            RD_HI_NEXT: rd_offset = ch_x2 + ADDR_W'(4);
            default:    rd_offset = '0;
        endcase
    end

    assign rd_addr = r_base + rd_offset;

    // Store write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
    end

    // Store read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Frame bookkeeping, idle counter and timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_held    <= '0;
            r_idle    <= '0;
            r_timeout <= TIMEOUT_RST;
            r_ch      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end

            if (i_cmd.enter_read) begin
                r_held <= '0;
                r_idle <= '0;
            end else if (i_cmd.wr_byte) begin
                if (r_held == '0) begin
                    r_idle <= '0;
                end
                if (!o_sts.frame_full) begin
                    r_held <= r_held + HELD_W'(1);
                end
            end else if (i_cmd.tick) begin
                if (r_idle != TICK_MAX) begin
                    r_idle <= r_idle + TICK_W'(1);
                end
            end else if (i_cmd.drop) begin
                r_base <= r_base + ADDR_W'(DROP_BYTES);
                r_held <= HELD_W'(FRAME_BYTES - DROP_BYTES);
            end else if (i_cmd.frame_done) begin
                r_held <= '0;
            end

            if (i_cmd.ch_clr) begin
                r_ch <= '0;
            end else if (i_cmd.ch_inc) begin
                r_ch <= r_ch + CH_W'(1);
            end
        end
    end

    // Latch header first byte and channel high byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr0_latch) begin
            r_hdr0_ok <= (r_rdata == CHAR_LT);
        end
        if (i_cmd.hi_latch) begin
            r_hi <= r_rdata;
        end
    end

    // Output register: load a result, drop it once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_kind <= i_cmd.out_kind;
            if (i_cmd.out_kind == KIND_CHAN) begin
                r_out_index <= 4'(r_ch);
                r_out_value <= {r_hi, r_rdata};
                r_out_last  <= o_sts.ch_last;
            end else begin
                r_out_index <= '0;
                r_out_value <= '0;
                r_out_last  <= 1'b1;
            end
        end
    end

    // Status
    assign o_sts.frame_full = (r_held == HELD_W'(FRAME_BYTES - 1));
    // Saturating increment exceeds the limit
    assign o_sts.tout_hit   = (r_idle != TICK_MAX) ? (r_idle >= r_timeout)
                                                   : (r_timeout != TICK_MAX);
    assign o_sts.hdr_ok     = r_hdr0_ok && (r_rdata == CHAR_D);
    assign o_sts.ch_last    = (r_ch == CH_W'(CHANNEL_COUNT - 1));
    assign o_sts.slot_free  = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_out_kind;
    assign o_out.channel_index = r_out_index;
    assign o_out.channel_value = r_out_value;
    assign o_out.last          = r_out_last;

endmodule

>>> rtl/gsfp_ctrl.sv
`timescale 1ns / 1ps

module gsfp_ctrl
    import gsfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_op,
    input  logic [7:0] i_rx_byte,
    input  t_sts       i_sts,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_LT,
        ST_SKIP,
        ST_READ,
        ST_HDR0,
        ST_HDR1,
        ST_CHECK,
        ST_CH_LO,
        ST_CH_PUT,
        ST_RESYNC,
        ST_TOUT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_skip, n_skip;
    logic       r_ready;
    logic       accept;

    assign accept  = i_valid && r_ready;
    assign o_ready = r_ready;

    // Decode inputs and sequence the frame readout
    always_comb begin
        n_state        = r_state;
        n_skip         = r_skip;
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_HDR0;
        o_cmd.out_kind = KIND_CHAN;
        case (r_state)
            ST_HUNT: begin
                if (accept && !i_op && i_rx_byte == CHAR_LT) begin
                    n_state = ST_LT;
                end
            end
            ST_LT: begin
                if (accept && !i_op) begin
                    if (i_rx_byte == CHAR_I) begin
                        n_state = ST_SKIP;
                        n_skip  = '0;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            end
            ST_SKIP: begin
                if (accept && !i_op) begin
                    if (r_skip == 3'(INFO_BYTES - 1)) begin
                        n_skip           = '0;
                        n_state          = ST_READ;
                        o_cmd.enter_read = 1'b1;
                    end else begin
                        n_skip = r_skip + 3'd1;
                    end
                end
            end
            ST_READ: begin
                if (accept) begin
                    if (i_op) begin
                        o_cmd.tick = 1'b1;
                        if (i_sts.tout_hit) begin
                            n_state = ST_TOUT;
                        end
                    end else begin
                        o_cmd.wr_byte = 1'b1;
                        if (i_sts.frame_full) begin
                            n_state = ST_HDR0;
                        end
                    end
                end
            end
            ST_HDR0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HDR0;
                o_cmd.ch_clr = 1'b1;
                n_state      = ST_HDR1;
            end
            ST_HDR1: begin
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_sel     = RD_HDR1;
                o_cmd.hdr0_latch = 1'b1;
                n_state          = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.hdr_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HI;
                    n_state      = ST_CH_LO;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = ST_RESYNC;
                end
            end
            ST_CH_LO: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_LO;
                o_cmd.hi_latch = 1'b1;
                n_state        = ST_CH_PUT;
            end
            ST_CH_PUT: begin
                // Hold the low byte until the output register frees up
                if (i_sts.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = KIND_CHAN;
                    if (i_sts.ch_last) begin
                        o_cmd.frame_done = 1'b1;
                        n_state          = ST_READ;
                    end else begin
                        o_cmd.ch_inc = 1'b1;
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RD_HI_NEXT;
                        n_state      = ST_CH_LO;
                    end
                end
            end
            ST_RESYNC: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = KIND_RESYNC;
                    n_state        = ST_READ;
                end
            end
            ST_TOUT: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_kind = KIND_TIMEOUT;
                    n_state        = ST_HUNT;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // Hold state, skip count and the registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_skip  <= '0;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_skip  <= n_skip;
            r_ready <= (n_state inside {ST_HUNT, ST_LT, ST_SKIP, ST_READ});
        end
    end

endmodule

>>> rtl/glove_sensor_frame_parser.sv
`timescale 1ns / 1ps

// Glove sensor frame parser.
// i_in carries one item per transfer: op 0 is a received serial byte in
// rx_byte, op 1 is one time tick. o_out carries results: channel values
// (kind 0, last set on the final channel), a resync status after a bad
// frame header (kind 1) and a timeout status (kind 2). The timeout limit
// is to be written through i_cfg_we / i_cfg_data while the block is idle;
// the block does not enforce this. A byte or tick that completes nothing
// keeps the block ready; a tick that times out loads its status once the
// output register is free. A byte that fills the frame stops intake for a
// readout of the 64-byte ring store through its single registered read
// port: header check in HDR0, HDR1, CHECK, then CH_LO and CH_PUT per
// channel; a bad header drops the frame front and loads a resync status.
// The output register lets a new item be taken while a result still waits;
// a stalled receiver holds the readout at the next result.
// Reset (synchronous, active low) returns to hunting for the start marker,
// empties the frame and restores the timeout limit to 2000 ticks.

module glove_sensor_frame_parser
    import gsfp_pkg::*;
#(
    parameter int FRAME_BYTES   = 36,
    parameter int CHANNEL_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    gsfp_in_if.sink           i_in,
    gsfp_out_if.source        o_out
);

    t_cmd cmd;
    t_sts sts;

    gsfp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_op      (i_in.op),
        .i_rx_byte (i_in.rx_byte),
        .i_sts     (sts),
        .o_ready   (i_in.ready),
        .o_cmd     (cmd)
    );

    gsfp_datapath #(
        .FRAME_BYTES   (FRAME_BYTES),
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_rx_byte  (i_in.rx_byte),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

>>> bench/gsfp_bench_pkg.sv
`timescale 1ns / 1ps

package gsfp_bench_pkg;

    // Item operations on the input channel
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Frame geometry used by the bench and the parser instance
    localparam int FRAME_LEN = 36;
    localparam int CHANNELS  = 16;

endpackage

>>> bench/gsfp_checker.sv
`timescale 1ns / 1ps

module gsfp_checker
    import gsfp_pkg::*;
    import gsfp_bench_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    gsfp_in_if                i_in,
    gsfp_out_if               i_out,
    output int                o_fail_count,
    output int                o_pending
);

    typedef enum logic [1:0] {
        HUNT_LT,
        HUNT_I,
        SKIP_INFO,
        READ_FRAME
    } t_parse_state;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  chan;
        logic [15:0] value;
        logic        last;
    } t_sensor_result;

    t_parse_state      parse_state;
    logic [2:0]        info_cnt;
    logic [7:0]        frame_buf [FRAME_LEN];
    int                held;
    logic [TICK_W-1:0] idle_cnt;
    logic [TICK_W-1:0] tmo_limit;
    t_sensor_result    due_results [$];
    int                fails = 0;

    function automatic t_sensor_result make_result(t_kind kind, logic [3:0] chan,
                                                   logic [15:0] value, logic last);
        t_sensor_result r;
        r.kind  = kind;
        r.chan  = chan;
        r.value = value;
        r.last  = last;
        return r;
    endfunction

    // Advance the parser by one accepted item and queue what it emits
    task automatic parse_item(input logic op, input logic [7:0] b);
        int k;
        if (op == OP_TICK) begin
            if (parse_state != READ_FRAME) return;
            if (idle_cnt != TICK_MAX) idle_cnt++;
            if (idle_cnt > tmo_limit) begin
                parse_state = HUNT_LT;
                due_results.push_back(make_result(KIND_TIMEOUT, 4'd0, 16'd0, 1'b1));
            end
            return;
        end
        case (parse_state)
            HUNT_LT: begin
                if (b == CHAR_LT) parse_state = HUNT_I;
            end
            HUNT_I: begin
                // a second '<' here is not a new start marker
                if (b == CHAR_I) begin
                    parse_state = SKIP_INFO;
                    info_cnt    = 3'd0;
                end else begin
                    parse_state = HUNT_LT;
                end
            end
            SKIP_INFO: begin
                info_cnt++;
                if (info_cnt >= INFO_BYTES) begin
                    info_cnt    = 3'd0;
                    parse_state = READ_FRAME;
                    held        = 0;
                    idle_cnt    = '0;
                end
            end
            default: begin
                // a byte opening a new frame restarts the idle count
                if (held == 0) idle_cnt = '0;
                frame_buf[held] = b;
                held++;
                if (held == FRAME_LEN) begin
                    if (frame_buf[0] == CHAR_LT && frame_buf[1] == CHAR_D) begin
                        for (k = 0; k < CHANNELS; k++)
                            due_results.push_back(make_result(KIND_CHAN, 4'(k),
                                {frame_buf[2*k+2], frame_buf[2*k+3]}, k == CHANNELS - 1));
                        held = 0;
                    end else begin
                        // drop the front of the frame, keep the tail
                        for (k = 0; k + DROP_BYTES < FRAME_LEN; k++)
                            frame_buf[k] = frame_buf[k + DROP_BYTES];
                        held = FRAME_LEN - DROP_BYTES;
                        due_results.push_back(make_result(KIND_RESYNC, 4'd0, 16'd0, 1'b1));
                    end
                end
            end
        endcase
    endtask

    // Compare one result transfer against the oldest expectation
    task automatic check_result();
        t_sensor_result got;
        t_sensor_result want;
        got = make_result(t_kind'(i_out.kind), i_out.channel_index,
                          i_out.channel_value, i_out.last);
        if (due_results.size() == 0) begin
            fails++;
            $display("%0t: unexpected result kind %0d index %0d value %04h last %0b",
                     $time, got.kind, got.chan, got.value, got.last);
        end else begin
            want = due_results.pop_front();
            if (got != want) begin
                fails++;
                $display("%0t: expected kind %0d index %0d value %04h last %0b,",
                         $time, want.kind, want.chan, want.value, want.last);
                $display("    got kind %0d index %0d value %04h last %0b",
                         got.kind, got.chan, got.value, got.last);
            end
        end
    endtask

    // Watch the config port and both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_state = HUNT_LT;
            info_cnt    = 3'd0;
            held        = 0;
            idle_cnt    = '0;
            tmo_limit   = TIMEOUT_RST;
            due_results.delete();
        end else begin
            if (i_cfg_we) tmo_limit = i_cfg_data;
            if (i_in.valid && i_in.ready) parse_item(i_in.op, i_in.rx_byte);
            if (i_out.valid && i_out.ready) check_result();
        end
        o_fail_count <= fails;
        o_pending    <= due_results.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import gsfp_pkg::*;
    import gsfp_bench_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [TICK_W-1:0] cfg_data;
    logic              calm;
    logic [TICK_W-1:0] tmo_now;
    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                items_sent  = 0;

    gsfp_in_if  in_ch ();
    gsfp_out_if out_ch ();

    glove_sensor_frame_parser #(
        .FRAME_BYTES   (FRAME_LEN),
        .CHANNEL_COUNT (CHANNELS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    gsfp_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, two long hold-offs while items keep coming
    initial begin : receiver
        int taken;
        int holds;
        taken = 0;
        holds = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) taken++;
            if (holds < 2 && taken >= (holds == 0 ? 40 : 150)) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds++;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 19);
            end
        end
    end

    function automatic logic [7:0] data_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CHAR_LT;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one item, maybe after a gap, and hold it until transferred
    task automatic send_item(input logic op, input logic [7:0] b);
        while (!calm && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom_range(255)));
    endtask

    // Start marker plus the info bytes
    task automatic send_start();
        send_byte(CHAR_LT);
        send_byte(CHAR_I);
        repeat (INFO_BYTES) send_byte(data_byte());
    endtask

    // One frame, good or broken header, with the odd tick mixed in
    task automatic send_frame(input bit good);
        logic [7:0] fb [FRAME_LEN];
        int k;
        for (k = 0; k < FRAME_LEN; k++) fb[k] = data_byte();
        if (good) begin
            fb[0] = CHAR_LT;
            fb[1] = CHAR_D;
        end else begin
            case ($urandom_range(2))
                0: begin
                    fb[0] = CHAR_LT;
                    if (fb[1] == CHAR_D) fb[1] = 8'h00;
                end
                1: begin
                    fb[0] = CHAR_D;
                    fb[1] = CHAR_LT;
                end
                default: begin
                    if (fb[0] == CHAR_LT) fb[0] = 8'hFF;
                    fb[1] = CHAR_D;
                end
            endcase
            // plant a header right after the dropped bytes half the time
            if ($urandom_range(1)) begin
                fb[DROP_BYTES]     = CHAR_LT;
                fb[DROP_BYTES + 1] = CHAR_D;
            end
        end
        for (k = 0; k < FRAME_LEN; k++) begin
            if ($urandom_range(99) < 5) send_tick();
            send_byte(fb[k]);
        end
    endtask

    // Mix of well-formed streams, resyncs, noise and tick bursts
    task automatic run_units(input int goal);
        int r;
        int n;
        while (items_sent < goal) begin
            r = $urandom_range(99);
            if (r < 55) begin
                send_start();
                repeat ($urandom_range(1, 2)) send_frame($urandom_range(99) < 80);
            end else if (r < 75) begin
                send_start();
                send_frame(1'b0);
                repeat (DROP_BYTES) send_byte(data_byte());
            end else if (r < 88) begin
                repeat ($urandom_range(3, 12)) begin
                    n = $urandom_range(99);
                    if (n < 25)      send_tick();
                    else if (n < 45) send_byte(CHAR_LT);
                    else if (n < 60) send_byte(CHAR_I);
                    else if (n < 68) send_byte(CHAR_D);
                    else             send_byte(8'($urandom_range(255)));
                end
            end else begin
                send_start();
                repeat ($urandom_range(0, 40)) send_byte(data_byte());
                n = (tmo_now < 30) ? int'(tmo_now) + $urandom_range(0, 2)
                                   : $urandom_range(1, 20);
                repeat (n) send_tick();
            end
        end
    endtask

    // Stop offering, let every expected result arrive, then let the block settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TICK_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        tmo_now  = v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : stimulus
        logic [TICK_W-1:0] tmo_plan [5];
        int p;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_data      <= '0;
        calm          <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_BYTE;
        in_ch.rx_byte <= 8'h00;
        tmo_now       = TIMEOUT_RST;
        tmo_plan      = '{24'd1, TICK_MAX, 24'd0, 24'd3, 24'd0};
        tmo_plan[4]   = TICK_W'($urandom_range(4, 40));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tick and stray bytes while hunting
        send_tick();
        send_byte(8'h00);
        send_byte(8'hFF);
        // start marker broken by another byte, then by a second '<'
        send_byte(CHAR_LT);
        send_byte(8'h58);
        send_byte(CHAR_I);
        send_byte(CHAR_LT);
        send_byte(CHAR_LT);
        send_byte(CHAR_I);
        // real start, info bytes at the extremes and marker values
        send_byte(CHAR_LT);
        send_byte(CHAR_I);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CHAR_LT);
        send_byte(CHAR_I);
        send_byte(CHAR_D);
        // ticks before the first frame byte
        send_tick();
        send_tick();
        send_frame(1'b1);
        send_frame(1'b1);

        run_units(items_sent + 40);
        for (p = 0; p < 5; p++) begin
            wait_drained();
            write_timeout(tmo_plan[p]);
            calm <= (p == 1);
            run_units(items_sent + 30);
        end
        calm <= 1'b0;
        wait_drained();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
